// ===== hw/rtl/rrqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared constants and types of the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_BURST_MS    = 10;

   localparam int PID_W     = 8;
   localparam int TIME_W    = 16;
   localparam int QUANTUM_W = 14;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 14'd100;

   // request kind, carried on req_tuser
   localparam logic ACT_DISPATCH = 1'b0;
   localparam logic ACT_ADMIT    = 1'b1;

   typedef struct packed {
      logic [PID_W-1:0]  served_pid;
      logic [TIME_W-1:0] left_ms;
      logic              finished;
      logic              idle;
      logic              arrival_dropped;
   } result_type;

endpackage

// ===== hw/rtl/round_robin_quantum_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core
// FIFO ready queue with round-robin dispatch: one scheduling step per word.
// ----------------------------------------------------------------------------
// Each request word is one scheduling step and yields exactly one response
// word. The block takes one word per clock while the response side keeps up.
// A taken request loads the input register; the queue update then fills
// the stage-1 register, and the output register holds the response word
// until the sink takes it.
// A stalled response holds the pipe; ready drops once all three registers
// are full. The ready queue is a register file read at the head and written
// at up to two tail slots per step, so the whole pop / admit / requeue update
// is combinational and is written with the stage-1 register.
// csr_wdata is the quantum in ms; the burst count derived from it is held in
// a register that is ready in the cycle after the write.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_core #(
   parameter int QUEUE_DEPTH = rrqs_pkg::DEF_QUEUE_DEPTH,
   parameter int BURST_MS    = rrqs_pkg::DEF_BURST_MS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // arrival_pid[7:0], arrival_time_ms[23:8]
   input  logic [0:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // served_pid[7:0], ran_ms[21:8], left_ms[37:22], finished[38], idle[39],
   // arrival_dropped[40], zero[47:41]
   output logic [47:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [13:0] csr_wdata
);

   localparam int PW    = rrqs_pkg::PID_W;
   localparam int TW    = rrqs_pkg::TIME_W;
   localparam int QW    = rrqs_pkg::QUANTUM_W;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LOG_B = $clog2(BURST_MS);

   // reciprocal constants: floor(x / BURST_MS) == (x * MUL) >> SH for x < 2**XW
   localparam int CFG_SH  = QW + LOG_B;
   localparam int CFG_MUL = ((1 << CFG_SH) + BURST_MS - 1) / BURST_MS;
   localparam int CFG_PW  = QW + QW + 1;
   localparam int RU_XW   = QW + 1;
   localparam int RU_SH   = RU_XW + LOG_B;
   localparam int RU_MUL  = ((1 << RU_SH) + BURST_MS - 1) / BURST_MS;
   localparam int RU_PW   = RU_XW + RU_XW + 1;
   localparam int MUL_W   = 2 * QW;

   localparam logic [QW-1:0] BURSTS_RESET =
      QW'(int'(rrqs_pkg::QUANTUM_RESET) / BURST_MS);

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
      advance = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   // ---------------- configuration ----------------
   logic [QW-1:0]     bursts_ff;
   logic [CFG_PW-1:0] cfg_prod;

   assign cfg_prod = CFG_PW'(csr_wdata) * CFG_PW'(CFG_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         bursts_ff <= BURSTS_RESET;
      end else if (csr_wen) begin
         bursts_ff <= QW'(cfg_prod >> CFG_SH);
      end
   end

   // ---------------- pipeline enables ----------------
   logic s0_valid_ff, s1_valid_ff, rsp_valid_ff;
   logic s0_en, s1_en, s2_en, s0_step;

   assign s2_en      = !rsp_valid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign s0_en      = !s0_valid_ff || s1_en;
   assign req_tready = s0_en;
   assign s0_step    = s0_valid_ff && s1_en;

   // ---------------- input register ----------------
   logic          s0_act_ff;
   logic [PW-1:0] s0_pid_ff;
   logic [TW-1:0] s0_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en && req_tvalid) begin
         s0_act_ff  <= req_tuser[0];
         s0_pid_ff  <= req_tdata[PW-1:0];
         s0_time_ff <= req_tdata[PW+TW-1:PW];
      end
   end

   // ---------------- ready queue ----------------
   logic [PW-1:0]    qid_ff  [QUEUE_DEPTH];
   logic [TW-1:0]    qrem_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] head_ff, tail_ff, head_in, tail_in, req_pos;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic             full, push_arr, dropped, empty_before, idle, over, requeue;
   logic [PW-1:0]    head_pid;
   logic [TW-1:0]    head_rem, left;
   logic [MUL_W-1:0] slice_prod;
   logic [QW-1:0]    slice, ru_q, given;
   logic [RU_XW-1:0] ru_x;
   logic [RU_PW-1:0] ru_prod;

   always_comb begin
      full         = (occ_ff == OCC_W'(QUEUE_DEPTH));
      push_arr     = (s0_act_ff == rrqs_pkg::ACT_ADMIT) && !full;
      dropped      = (s0_act_ff == rrqs_pkg::ACT_ADMIT) && full;
      empty_before = (occ_ff == '0);
      idle         = empty_before && !push_arr;

      // an arrival into an empty queue is served straight away
      head_pid = empty_before ? s0_pid_ff  : qid_ff[head_ff];
      head_rem = empty_before ? s0_time_ff : qrem_ff[head_ff];

      // whole bursts of the quantum, in ms
      slice_prod = MUL_W'(bursts_ff) * MUL_W'(BURST_MS);
      slice      = slice_prod[QW-1:0];
      over       = head_rem > TW'(slice);
      left       = over ? head_rem - TW'(slice) : '0;
      requeue    = !idle && over;

      // bursts needed to finish: ceil(rem / BURST_MS); only used when rem <= slice
      ru_x    = RU_XW'(head_rem[QW-1:0]) + RU_XW'(BURST_MS - 1);
      ru_prod = RU_PW'(ru_x) * RU_PW'(RU_MUL);
      ru_q    = QW'(ru_prod >> RU_SH);
      given   = over ? bursts_ff : ru_q;

      req_pos = push_arr ? advance(tail_ff) : tail_ff;
      tail_in = requeue ? advance(req_pos) : req_pos;
      head_in = idle ? head_ff : advance(head_ff);
      occ_in  = occ_ff + OCC_W'(push_arr) - OCC_W'(!idle) + OCC_W'(requeue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (s0_step) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_step && push_arr) begin
         qid_ff[tail_ff]  <= s0_pid_ff;
         qrem_ff[tail_ff] <= s0_time_ff;
      end
      if (s0_step && requeue) begin
         qid_ff[req_pos]  <= head_pid;
         qrem_ff[req_pos] <= left;
      end
   end

   // ---------------- stage 1 ----------------
   rrqs_pkg::result_type s1_res_ff, rsp_res_ff;
   logic [QW-1:0]        s1_given_ff, rsp_ran_ff;
   logic [MUL_W-1:0]     ran_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_step) begin
         s1_res_ff.served_pid      <= idle ? '0 : head_pid;
         s1_res_ff.left_ms         <= idle ? '0 : left;
         s1_res_ff.finished        <= !idle && !over;
         s1_res_ff.idle            <= idle;
         s1_res_ff.arrival_dropped <= dropped;
         s1_given_ff               <= idle ? '0 : given;
      end
   end

   // ---------------- output register ----------------
   assign ran_prod = MUL_W'(s1_given_ff) * MUL_W'(BURST_MS);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         rsp_res_ff <= s1_res_ff;
         rsp_ran_ff <= ran_prod[QW-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_res_ff.arrival_dropped, rsp_res_ff.idle,
                        rsp_res_ff.finished, rsp_res_ff.left_ms, rsp_ran_ff,
                        rsp_res_ff.served_pid};

   // ---------------- assertions ----------------
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0 || occ_ff == OCC_W'(QUEUE_DEPTH)) |-> head_ff == tail_ff)
      else $error("head and tail apart on empty or full queue");

   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (s0_step && full && s0_act_ff == rrqs_pkg::ACT_ADMIT)
         |=> s1_res_ff.arrival_dropped)
      else $error("arrival into full queue not flagged");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_res_ff.idle) |-> (!s1_res_ff.finished && s1_given_ff == '0))
      else $error("idle step carries dispatch data");

endmodule

// ===== bench/tb_round_robin_quantum_scheduler_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_quantum_scheduler_core
// Self-checking bench for the round-robin quantum scheduler. A local queue
// model predicts every response word. The stimulus covers the empty, full and
// zero-time cases and the quantum extremes. Random phases follow, each with
// its own quantum and traffic mix, under random source and sink stalls.
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler_core;

   localparam int DEPTH        = rrqs_pkg::DEF_QUEUE_DEPTH;
   localparam int BURST        = rrqs_pkg::DEF_BURST_MS;
   localparam int PID_W        = rrqs_pkg::PID_W;
   localparam int TIME_W       = rrqs_pkg::TIME_W;
   localparam int QUANTUM_W    = rrqs_pkg::QUANTUM_W;
   localparam int LATENCY      = 3;
   localparam int RANDOM_STEPS = 1370;

   // traffic mixes of the random phases
   localparam int MIX_FILL  = 0;
   localparam int MIX_CHURN = 1;
   localparam int MIX_DRAIN = 2;

   typedef struct {
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] remaining;
   } proc_type;

   typedef struct {
      logic [PID_W-1:0]     served_pid;
      logic [QUANTUM_W-1:0] ran_ms;
      logic [TIME_W-1:0]    left_ms;
      logic                 finished;
      logic                 idle;
      logic                 arrival_dropped;
   } turn_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // arrival_pid[7:0], arrival_time_ms[23:8]
   logic [0:0]  req_tuser   = '0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // served_pid[7:0], ran_ms[21:8], left_ms[37:22], finished[38], idle[39],
   // arrival_dropped[40], zero[47:41]
   logic [47:0] rsp_tdata;
   logic        csr_wen     = 1'b0;
   logic [13:0] csr_wdata   = '0;

   proc_type             ready_procs[$];
   turn_type             expected_turns[$];
   logic [QUANTUM_W-1:0] quantum_cfg = rrqs_pkg::QUANTUM_RESET;
   int                   err_count   = 0;
   bit                   src_gaps    = 1'b0;
   bit                   sink_stalls = 1'b0;
   int                   sink_hold   = 0;

   round_robin_quantum_scheduler_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 9);
      return $urandom_range(10, 40);
   endfunction

   // one scheduling step on the local queue copy
   function automatic turn_type schedule_step(input logic act,
                                              input logic [PID_W-1:0] pid,
                                              input logic [TIME_W-1:0] ms);
      turn_type res;
      proc_type p;
      int       bursts;
      int       need;
      int       given;
      int       rem;
      res = '{default: '0};
      if (act == rrqs_pkg::ACT_ADMIT) begin
         if (ready_procs.size() >= DEPTH) begin
            res.arrival_dropped = 1'b1;
         end else begin
            p.pid       = pid;
            p.remaining = ms;
            ready_procs.push_back(p);
         end
      end
      if (ready_procs.size() == 0) begin
         res.idle = 1'b1;
         return res;
      end
      p      = ready_procs.pop_front();
      bursts = int'(quantum_cfg) / BURST;
      need   = (int'(p.remaining) + BURST - 1) / BURST;
      given  = (need < bursts) ? need : bursts;
      rem    = int'(p.remaining) - given * BURST;
      if (rem < 0) rem = 0;
      if (rem != 0) begin
         p.remaining = TIME_W'(rem);
         ready_procs.push_back(p);
      end
      res.served_pid = p.pid;
      res.ran_ms     = QUANTUM_W'(given * BURST);
      res.left_ms    = TIME_W'(rem);
      res.finished   = (rem == 0);
      return res;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // sink side: random stalls
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold  = sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
         sink_hold  = idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      turn_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_turns.size() == 0) begin
            $error("response word with no step outstanding: %h", rsp_tdata);
            err_count++;
         end else begin
            want = expected_turns.pop_front();
            check_field("served_pid", want.served_pid, rsp_tdata[7:0]);
            check_field("ran_ms", want.ran_ms, rsp_tdata[21:8]);
            check_field("left_ms", want.left_ms, rsp_tdata[37:22]);
            check_field("finished", want.finished, rsp_tdata[38]);
            check_field("idle", want.idle, rsp_tdata[39]);
            check_field("arrival_dropped", want.arrival_dropped, rsp_tdata[40]);
            check_field("pad", 0, rsp_tdata[47:41]);
         end
      end
   end

   // called at a rising edge; returns at the edge that took the word
   task automatic run_step(input logic act, input logic [PID_W-1:0] pid,
                           input logic [TIME_W-1:0] ms);
      int gap;
      gap = (src_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {ms, pid};
      do @(posedge clock); while (!req_tready);
      expected_turns.push_back(schedule_step(act, pid, ms));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_turns.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= q;
      @(posedge clock);
      csr_wen     <= 1'b0;
      quantum_cfg = q;
      // burst count register is ready in the cycle after the write
      repeat (2) @(posedge clock);
   endtask

   task automatic test_empty_and_zero_time();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      run_step(rrqs_pkg::ACT_DISPATCH, 8'hFF, 16'hFFFF);   // empty queue
      run_step(rrqs_pkg::ACT_ADMIT, 8'h00, 16'h0000);      // zero time, served at once
      run_step(rrqs_pkg::ACT_ADMIT, 8'hFF, 16'd7);         // partial last burst
      run_step(rrqs_pkg::ACT_ADMIT, 8'h5A, 16'd100);       // ends exactly on the quantum
      run_step(rrqs_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
   endtask

   task automatic test_full_queue();
      int i;
      sink_stalls = 1'b1;
      // each long admit adds one until full; the last and the next admit are dropped
      for (i = 0; i < DEPTH + 1; i++) begin
         run_step(rrqs_pkg::ACT_ADMIT, (i == 0) ? 8'hFF : PID_W'(i),
                  (i == 0) ? 16'hFFFF : TIME_W'(50000 + i));
      end
      run_step(rrqs_pkg::ACT_ADMIT, 8'h00, 16'h0000);
      wait_idle();
   endtask

   task automatic test_quantum_extremes();
      set_quantum('0);              // no bursts, job requeued as is
      run_step(rrqs_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
      set_quantum(14'd9);
      run_step(rrqs_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
      set_quantum('1);              // above the nominal range
      run_step(rrqs_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
      run_step(rrqs_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
      set_quantum(14'd10);
      run_step(rrqs_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
      set_quantum(14'd10000);
      run_step(rrqs_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
   endtask

   task automatic test_random_traffic();
      int                   done;
      int                   len;
      int                   mix;
      int                   admit_pct;
      int                   i;
      int                   r;
      logic [QUANTUM_W-1:0] q;
      logic                 act;
      logic [TIME_W-1:0]    ms;
      done = 0;
      while (done < RANDOM_STEPS) begin
         mix = $urandom_range(MIX_FILL, MIX_DRAIN);
         case ($urandom_range(0, 9))
            0: q = '0;
            1: q = 14'd9;
            2: q = 14'd10;
            3: q = '1;
            default: begin
               if (mix == MIX_DRAIN) q = QUANTUM_W'($urandom_range(1000, 16383));
               else                  q = QUANTUM_W'($urandom_range(10, 200));
            end
         endcase
         set_quantum(q);
         src_gaps    = ($urandom_range(0, 3) != 0);
         sink_stalls = ($urandom_range(0, 3) != 0);
         admit_pct   = (mix == MIX_FILL) ? 85 : (mix == MIX_CHURN) ? 50 : 15;
         len         = $urandom_range(40, 120);
         for (i = 0; i < len; i++) begin
            act = ($urandom_range(0, 99) < admit_pct) ? rrqs_pkg::ACT_ADMIT
                                                      : rrqs_pkg::ACT_DISPATCH;
            r   = $urandom_range(0, 9);
            if (r == 0)                 ms = '0;
            else if (r == 1)            ms = '1;
            else if (mix == MIX_FILL)   ms = TIME_W'($urandom_range(1000, 65535));
            else if (mix == MIX_CHURN)  ms = TIME_W'($urandom_range(1, 300));
            else                        ms = TIME_W'($urandom_range(0, 65535));
            run_step(act, PID_W'($urandom_range(0, 255)), ms);
            // let the pipe run dry mid-phase now and then
            if (i == len / 2 && (done == 0 || $urandom_range(0, 2) == 0)) wait_idle();
         end
         done += len;
      end
   endtask

   initial begin
      int w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_zero_time();
      test_full_queue();
      test_quantum_extremes();
      test_random_traffic();
      req_tvalid <= 1'b0;
      for (w = 0; w < 2000 && expected_turns.size() != 0; w++) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (expected_turns.size() != 0) begin
         $error("%0d steps never answered", expected_turns.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/rrqs_pkg.sv
hw/rtl/round_robin_quantum_scheduler_core.sv
bench/tb_round_robin_quantum_scheduler_core.sv
